[rtl/core/btr_pkg.sv]
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types, constants and the character map of the bitmap text renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

  // Font store geometry. A slot is 6 bits wide, so at most 64 slots exist.
  localparam int GLYPH_COUNT_DEF = 64;
  localparam int MAX_SLOTS       = 64;
  localparam int GLYPH_ROWS      = 8;
  localparam int FULL_AW         = 9;

  // Drawing offsets added to the pixel column and line.
  localparam int X_MARGIN = 0;
  localparam int Y_MARGIN = 0;

  // Pixel column and line: 12 + 12 bits plus a margin below 1024 fit in 14.
  localparam int POS_W  = 14;
  // Line offset product: 14-bit line times 16-bit pitch.
  localparam int PROD_W = 30;

  localparam logic [11:0] COL_STEP  = 12'd8;
  localparam logic [11:0] LINE_STEP = 12'd8;

  // Character codes.
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_LT      = 8'h3C;
  localparam logic [7:0] CHAR_QMARK   = 8'h3F;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // First glyph slot of each character group.
  localparam logic [7:0] SLOT_DIGIT = 8'd26;
  localparam logic [7:0] SLOT_PUNCT = 8'd36;
  localparam logic [5:0] SLOT_STAR  = 6'd40;
  localparam logic [5:0] SLOT_MINUS = 6'd41;
  localparam logic [5:0] SLOT_SPACE = 6'd42;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CHAR = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_LINE_PITCH    = 3'd2,
    REG_INK_COLOR     = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_FRAME_BASE    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_DRAWN   = 2'd0,
    ST_CTRL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_ADDR,
    D_FIRST,
    D_DRAW
  } draw_state_t;

  // Configuration register set.
  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [15:0] line_pitch;
    logic [31:0] ink_color;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [31:0] frame_base;
  } cfg_t;

  // Decision taken for one accepted item, handed from cursor to drawing unit.
  typedef struct packed {
    logic             draw;
    status_t          status;
    logic [5:0]       glyph;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
  } dec_t;

  // Maps a character code to {hit, slot}; hit is low for codes with no glyph.
  function automatic logic [6:0] map_code(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] res;
    d   = 8'd0;
    res = 7'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d   = c - CHAR_UPPER_A;
      res = {1'b1, d[5:0]};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d   = c - CHAR_DIGIT_0 + SLOT_DIGIT;
      res = {1'b1, d[5:0]};
    end else if (c >= CHAR_LT && c <= CHAR_QMARK) begin
      d   = c - CHAR_LT + SLOT_PUNCT;
      res = {1'b1, d[5:0]};
    end else if (c == CHAR_STAR) begin
      res = {1'b1, SLOT_STAR};
    end else if (c == CHAR_MINUS) begin
      res = {1'b1, SLOT_MINUS};
    end else if (c == CHAR_SPACE) begin
      res = {1'b1, SLOT_SPACE};
    end
    return res;
  endfunction

endpackage

[rtl/core/btr_ram.sv]
// ----------------------------------------------------------------------------
// btr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module btr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 512,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/btr_cursor.sv]
// ----------------------------------------------------------------------------
// btr_cursor
// Text cursor and halt flag; classifies each accepted item and moves the
// cursor accordingly.
// ----------------------------------------------------------------------------
module btr_cursor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          commit,
  input  logic          first,
  input  logic          is_char,
  input  logic [7:0]    code,
  input  btr_pkg::cfg_t cfg,
  output btr_pkg::dec_t dec
);
  import btr_pkg::*;

  logic [11:0] col_r, col_nxt;
  logic [11:0] line_r, line_nxt;
  logic        halted_r, halted_nxt;

  logic [11:0] col_eff, line_eff, col_mv, line_mv;
  logic        halt_eff, nospace, glyph_hit;
  logic [6:0]  map;
  logic [12:0] line_sum, col_sum;

  // Classification and next cursor position.
  always_comb begin
    col_eff   = first ? 12'd0 : col_r;
    line_eff  = first ? 12'd0 : line_r;
    halt_eff  = first ? 1'b0 : halted_r;
    line_sum  = {1'b0, line_eff} + {1'b0, cfg.origin_y};
    nospace   = halt_eff || (line_sum >= cfg.screen_height);
    map       = map_code(code);
    glyph_hit = map[6];

    dec.glyph = map[5:0];
    dec.px    = POS_W'(cfg.origin_x) + POS_W'(col_eff) + POS_W'(X_MARGIN);
    dec.py    = POS_W'(cfg.origin_y) + POS_W'(line_eff) + POS_W'(Y_MARGIN);
    dec.draw  = 1'b0;

    col_nxt    = col_eff;
    line_nxt   = line_eff;
    halted_nxt = halt_eff;
    col_mv     = col_eff;
    line_mv    = line_eff;
    col_sum    = 13'd0;

    priority if (!is_char) begin
      dec.status = ST_DRAWN;
    end else if (nospace) begin
      dec.status = ST_NOSPACE;
      halted_nxt = 1'b1;
    end else begin
      priority if (glyph_hit) begin
        dec.status = ST_DRAWN;
        dec.draw   = 1'b1;
        col_mv     = col_eff + COL_STEP;
      end else if (code == CHAR_CR) begin
        dec.status = ST_CTRL;
        col_mv     = 12'd0;
      end else if (code == CHAR_LF) begin
        dec.status = ST_CTRL;
        col_mv     = 12'd0;
        line_mv    = line_eff + LINE_STEP;
      end else begin
        dec.status = ST_UNKNOWN;
        col_mv     = col_eff + COL_STEP;
      end
      // Wrap to the next text line at the column limit.
      col_sum = {1'b0, col_mv} + {1'b0, cfg.origin_x};
      if (col_sum >= cfg.screen_width) begin
        col_nxt  = 12'd0;
        line_nxt = line_mv + LINE_STEP;
      end else begin
        col_nxt  = col_mv;
        line_nxt = line_mv;
      end
    end
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= 12'd0;
      line_r   <= 12'd0;
      halted_r <= 1'b0;
    end else if (commit) begin
      col_r    <= col_nxt;
      line_r   <= line_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

[rtl/core/btr_draw.sv]
// ----------------------------------------------------------------------------
// btr_draw
// Glyph drawing sequencer: fetches glyph rows from the font store, forms the
// pixel writes and holds the result output register.
// ----------------------------------------------------------------------------
module btr_draw (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  btr_pkg::dec_t                dec,
  input  btr_pkg::cfg_t                cfg,
  output logic                         busy,
  output logic                         out_free,
  output logic                         rd_en,
  output logic [btr_pkg::FULL_AW-1:0]  rd_addr,
  input  logic [7:0]                   rd_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  out_pixel_address,
  output logic [31:0]                  out_pixel_value,
  output logic                         out_write_valid,
  output logic [1:0]                   out_status,
  output logic                         out_last
);
  import btr_pkg::*;

  draw_state_t       state_r, state_nxt;
  logic [5:0]        glyph_r, glyph_nxt;
  logic [POS_W-1:0]  px_r, px_nxt;
  logic [POS_W-1:0]  py_r, py_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [31:0]       row_addr_r, row_addr_nxt;
  logic [7:0]        bits_r, bits_nxt;
  logic [5:0]        pix_r, pix_nxt;

  logic              valid_r, valid_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       value_r, value_nxt;
  logic              wv_r, wv_nxt;
  status_t           status_r, status_nxt;
  logic              last_r, last_nxt;

  logic [2:0]        col;
  logic [2:0]        row;

  assign out_free = !valid_r || !out_stall;
  assign busy     = (state_r != D_IDLE);
  assign col      = pix_r[2:0];
  assign row      = pix_r[5:3];

  // Sequencer and output register next state.
  always_comb begin
    state_nxt    = state_r;
    glyph_nxt    = glyph_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    prod_nxt     = prod_r;
    row_addr_nxt = row_addr_r;
    bits_nxt     = bits_r;
    pix_nxt      = pix_r;
    valid_nxt    = valid_r && !out_free;
    addr_nxt     = addr_r;
    value_nxt    = value_r;
    wv_nxt       = wv_r;
    status_nxt   = status_r;
    last_nxt     = last_r;
    rd_en        = 1'b0;
    rd_addr      = {glyph_r, 3'd0};

    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          if (dec.draw) begin
            glyph_nxt = dec.glyph;
            px_nxt    = dec.px;
            py_nxt    = dec.py;
            state_nxt = D_MUL;
          end else begin
            // Non-drawing items give one result with no pixel write.
            valid_nxt  = 1'b1;
            addr_nxt   = 32'd0;
            value_nxt  = 32'd0;
            wv_nxt     = 1'b0;
            status_nxt = dec.status;
            last_nxt   = 1'b1;
          end
        end
      end
      D_MUL: begin
        prod_nxt  = py_r * cfg.line_pitch;
        state_nxt = D_ADDR;
      end
      D_ADDR: begin
        // Address of the first glyph row and fetch of its bits.
        row_addr_nxt = cfg.frame_base + {2'd0, prod_r} + {16'd0, px_r, 2'b00};
        rd_en        = 1'b1;
        rd_addr      = {glyph_r, 3'd0};
        pix_nxt      = 6'd0;
        state_nxt    = D_FIRST;
      end
      D_FIRST: begin
        bits_nxt  = rd_data;
        state_nxt = D_DRAW;
      end
      D_DRAW: begin
        if (out_free) begin
          valid_nxt  = 1'b1;
          addr_nxt   = row_addr_r + {27'd0, col, 2'b00};
          value_nxt  = bits_r[3'd7 - col] ? cfg.ink_color : 32'd0;
          wv_nxt     = 1'b1;
          status_nxt = ST_DRAWN;
          last_nxt   = (pix_r == 6'd63);
          pix_nxt    = pix_r + 6'd1;
          // Prefetch the next glyph row at the start of each row but the last.
          if (col == 3'd0 && row != 3'd7) begin
            rd_en   = 1'b1;
            rd_addr = {glyph_r, row + 3'd1};
          end
          if (col == 3'd7) begin
            bits_nxt     = rd_data;
            row_addr_nxt = row_addr_r + {16'd0, cfg.line_pitch};
          end
          if (pix_r == 6'd63) begin
            state_nxt = D_IDLE;
          end
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      valid_r <= 1'b0;
      pix_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      pix_r   <= pix_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    glyph_r    <= glyph_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    prod_r     <= prod_nxt;
    row_addr_r <= row_addr_nxt;
    bits_r     <= bits_nxt;
    addr_r     <= addr_nxt;
    value_r    <= value_nxt;
    wv_r       <= wv_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_value   = value_r;
  assign out_write_valid   = wv_r;
  assign out_status        = status_r;
  assign out_last          = last_r;

endmodule

[rtl/core/bitmap_text_renderer_top.sv]
// ----------------------------------------------------------------------------
// bitmap_text_renderer_top
// Renders 8x8 bitmap-font text into a 32-bit framebuffer as pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes load items, which write one
//   glyph row into the font store, and character items, which draw a glyph.
//   The result channel (out_valid / out_stall) carries pixel writes and status
//   results; out_last marks the final result of each item.
//   A load item, control character, unknown character or out-of-space item
//   gives one result, registered in the cycle after the transfer; such items may
//   follow each other in consecutive cycles while the output is taken.
//   A drawn character gives 64 pixel writes. After the transfer come the
//   line multiply and the first row fetch, then one pixel per cycle while
//   the receiver does not stall, through the single output register.
//   When the receiver stalls, the output register holds and the sequence
//   waits; in_stall stays high until the last pixel is in the register.
//   Configuration writes (cfg_valid / cfg_ready) are taken in any cycle and
//   must only be made while the block is idle.
//   Reset restores the configuration defaults and clears the cursor and the
//   halt flag. The font store is not cleared: rows must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_text_renderer_top #(
  parameter int GLYPH_COUNT = btr_pkg::GLYPH_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic        in_first_of_string,
  input  logic [7:0]  in_char_code,
  input  logic [5:0]  in_glyph_slot,
  input  logic [2:0]  in_glyph_row,
  input  logic [7:0]  in_row_bits,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_address,
  output logic [31:0] out_pixel_value,
  output logic        out_write_valid,
  output logic [1:0]  out_status,
  output logic        out_last,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import btr_pkg::*;

  localparam int FONT_SLOTS = (GLYPH_COUNT < MAX_SLOTS) ? GLYPH_COUNT : MAX_SLOTS;
  localparam int FONT_DEPTH = FONT_SLOTS * GLYPH_ROWS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);

  cfg_t               cfg_r;
  logic               in_xfer;
  logic               busy, out_free;
  logic               font_we;
  logic [FULL_AW-1:0] wr_full;
  logic               rd_en;
  logic [FULL_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  dec_t               dec;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= 12'd0;
      cfg_r.origin_y      <= 12'd0;
      cfg_r.line_pitch    <= 16'd4096;
      cfg_r.ink_color     <= 32'h00FF_FFFF;
      cfg_r.screen_width  <= 13'd1024;
      cfg_r.screen_height <= 13'd768;
      cfg_r.frame_base    <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata[11:0];
        REG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata[11:0];
        REG_LINE_PITCH:    cfg_r.line_pitch    <= cfg_wdata[15:0];
        REG_INK_COLOR:     cfg_r.ink_color     <= cfg_wdata;
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[12:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[12:0];
        REG_FRAME_BASE:    cfg_r.frame_base    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input transfer: only while idle and with room in the output register.
  assign in_stall = busy || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // Font row load; slots beyond the glyph count are dropped.
  assign wr_full = {in_glyph_slot, in_glyph_row};
  assign font_we = in_xfer && (in_opcode == OP_LOAD) && (32'(in_glyph_slot) < FONT_SLOTS);

  btr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (wr_full[FONT_AW-1:0]),
    .wdata (in_row_bits),
    .re    (rd_en),
    .raddr (rd_addr[FONT_AW-1:0]),
    .rdata (rd_data)
  );

  btr_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (in_xfer),
    .first   (in_first_of_string),
    .is_char (in_opcode == OP_CHAR),
    .code    (in_char_code),
    .cfg     (cfg_r),
    .dec     (dec)
  );

  btr_draw u_draw (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (in_xfer),
    .dec               (dec),
    .cfg               (cfg_r),
    .busy              (busy),
    .out_free          (out_free),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_write_valid   (out_write_valid),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule

[rtl/core/btr_checker.sv]
// ----------------------------------------------------------------------------
// btr_checker
// Port-level assertions for the bitmap text renderer, bound to the top level.
// ----------------------------------------------------------------------------
module btr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pixel_address,
  input logic [31:0] out_pixel_value,
  input logic        out_write_valid,
  input logic [1:0]  out_status,
  input logic        out_last
);
  import btr_pkg::*;

  // A result without a pixel write is always the only result of its item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_last)
    else $error("non-write result without last");

  // A result without a pixel write carries a zero address and value.
  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_pixel_address == 32'd0 &&
    out_pixel_value == 32'd0)
    else $error("non-write result with payload");

  // No new item is taken while a glyph is part way through its pixels.
  a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid && !out_last |-> in_stall)
    else $error("input taken during a pixel burst");

  // Pixel writes always report a drawn status.
  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_status == ST_DRAWN)
    else $error("pixel write with non-drawn status");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_address) &&
    $stable(out_pixel_value) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind bitmap_text_renderer_top btr_checker u_btr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pixel_address (out_pixel_address),
  .out_pixel_value   (out_pixel_value),
  .out_write_valid   (out_write_valid),
  .out_status        (out_status),
  .out_last          (out_last)
);

[dv/bitmap_text_renderer_top_tb.sv]
// ----------------------------------------------------------------------------
// bitmap_text_renderer_top_tb
// Self-checking bench for the text renderer. Load and character items are
// driven on the input channel with random gaps, and the result channel is
// stalled at random. Every accepted item is predicted by a scoreboard that
// keeps its own font store, cursor and register copy. Every pixel write and
// status result is then checked field by field against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitmap_text_renderer_top_tb;
  import btr_pkg::*;

  localparam int CYCLE_LIMIT      = 12_000_000;
  localparam int DRAIN_CYCLES     = 80;
  localparam int RANDOM_PER_PHASE = 16;
  localparam int REPORT_CAP       = 200;

  typedef struct packed {
    opcode_t     op;
    logic        first;
    logic [7:0]  code;
    logic [5:0]  slot;
    logic [2:0]  grow;
    logic [7:0]  gbits;
  } render_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] value;
    logic        wr;
    status_t     status;
    logic        last;
  } pixel_result_t;

  // Glyph slot of a character code, or -1 where the font has no glyph.
  function automatic int slot_for_code(logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c) - int'(CHAR_UPPER_A);
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
      return int'(c) - int'(CHAR_DIGIT_0) + int'(SLOT_DIGIT);
    if (c >= CHAR_LT && c <= CHAR_QMARK) return int'(c) - int'(CHAR_LT) + int'(SLOT_PUNCT);
    if (c == CHAR_STAR) return int'(SLOT_STAR);
    if (c == CHAR_MINUS) return int'(SLOT_MINUS);
    if (c == CHAR_SPACE) return int'(SLOT_SPACE);
    return -1;
  endfunction

  // Character code that draws a given glyph slot (0 to 42).
  function automatic logic [7:0] code_for_slot(int s);
    if (s < int'(SLOT_DIGIT)) return CHAR_UPPER_A + 8'(s);
    if (s < int'(SLOT_PUNCT)) return CHAR_DIGIT_0 + 8'(s - int'(SLOT_DIGIT));
    if (s < int'(SLOT_STAR)) return CHAR_LT + 8'(s - int'(SLOT_PUNCT));
    if (s == int'(SLOT_STAR)) return CHAR_STAR;
    if (s == int'(SLOT_MINUS)) return CHAR_MINUS;
    return CHAR_SPACE;
  endfunction

  // A code with no glyph that is neither carriage return nor line feed.
  function automatic logic [7:0] unknown_code();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (slot_for_code(c) >= 0 || c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Scoreboard: renders each accepted item into the pixel writes it must give.
  class text_render_board;
    logic [7:0]    glyph_store [512];
    logic [11:0]   cur_col;
    logic [11:0]   cur_line;
    bit            halted;
    logic [11:0]   origin_x;
    logic [11:0]   origin_y;
    logic [15:0]   line_pitch;
    logic [31:0]   ink;
    logic [12:0]   scr_width;
    logic [12:0]   scr_height;
    logic [31:0]   frame_base;
    pixel_result_t expected_pixels [$];
    int            errors;

    function new();
      foreach (glyph_store[i]) glyph_store[i] = 8'h00;
      cur_col    = '0;
      cur_line   = '0;
      halted     = 1'b0;
      origin_x   = '0;
      origin_y   = '0;
      line_pitch = 16'd4096;
      ink        = 32'h00FF_FFFF;
      scr_width  = 13'd1024;
      scr_height = 13'd768;
      frame_base = '0;
      errors     = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] d);
      case (idx)
        REG_ORIGIN_X:      origin_x   = d[11:0];
        REG_ORIGIN_Y:      origin_y   = d[11:0];
        REG_LINE_PITCH:    line_pitch = d[15:0];
        REG_INK_COLOR:     ink        = d;
        REG_SCREEN_WIDTH:  scr_width  = d[12:0];
        REG_SCREEN_HEIGHT: scr_height = d[12:0];
        REG_FRAME_BASE:    frame_base = d;
        default: ;
      endcase
    endfunction

    function void push_result(logic [31:0] addr, logic [31:0] value, logic wr,
                              status_t st, logic last);
      pixel_result_t r;
      r.addr   = addr;
      r.value  = value;
      r.wr     = wr;
      r.status = st;
      r.last   = last;
      expected_pixels.push_back(r);
    endfunction

    // Note one accepted input transfer and queue the results it causes.
    function void note_item(render_item_t it);
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] row_addr;
      logic [7:0]  rbits;
      int          g;
      status_t     st;
      bit          drew;
      drew = 1'b0;
      st   = ST_DRAWN;
      if (it.first) begin
        cur_col  = '0;
        cur_line = '0;
        halted   = 1'b0;
      end
      if (it.op == OP_LOAD) begin
        if (int'(it.slot) < GLYPH_COUNT_DEF) glyph_store[{it.slot, it.grow}] = it.gbits;
        push_result('0, '0, 1'b0, ST_DRAWN, 1'b1);
        return;
      end
      // Out of space is decided before anything else and then sticks.
      if (halted || 32'(cur_line) + 32'(origin_y) >= 32'(scr_height)) begin
        halted = 1'b1;
        push_result('0, '0, 1'b0, ST_NOSPACE, 1'b1);
        return;
      end
      g = slot_for_code(it.code);
      if (g >= 0) begin
        px = 32'(origin_x) + 32'(cur_col) + 32'(X_MARGIN);
        py = 32'(origin_y) + 32'(cur_line) + 32'(Y_MARGIN);
        for (int i = 0; i < 8; i++) begin
          rbits    = glyph_store[g * 8 + i];
          row_addr = frame_base + (py + 32'(i)) * 32'(line_pitch) + px * 32'd4;
          for (int j = 0; j < 8; j++)
            push_result(row_addr + 32'(j) * 32'd4, rbits[7 - j] ? ink : 32'h0, 1'b1,
                        ST_DRAWN, i == 7 && j == 7);
        end
        cur_col = cur_col + COL_STEP;
        drew    = 1'b1;
      end else if (it.code == CHAR_CR) begin
        cur_col = '0;
        st      = ST_CTRL;
      end else if (it.code == CHAR_LF) begin
        cur_col  = '0;
        cur_line = cur_line + LINE_STEP;
        st       = ST_CTRL;
      end else begin
        cur_col = cur_col + COL_STEP;
        st      = ST_UNKNOWN;
      end
      // Wrap to the next text line at the column limit.
      if (32'(cur_col) + 32'(origin_x) >= 32'(scr_width)) begin
        cur_col  = '0;
        cur_line = cur_line + LINE_STEP;
      end
      if (!drew) push_result('0, '0, 1'b0, st, 1'b1);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    // Check one accepted result transfer against the oldest expectation.
    function void check_pixel(pixel_result_t got);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $error("unexpected result: address 0x%0h, value 0x%0h", got.addr, got.value);
        return;
      end
      want = expected_pixels.pop_front();
      compare("pixel_address", want.addr, got.addr);
      compare("pixel_value", want.value, got.value);
      compare("write_valid", 32'(want.wr), 32'(got.wr));
      compare("status", 32'(want.status), 32'(got.status));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic        in_first_of_string;
  logic [7:0]  in_char_code;
  logic [5:0]  in_glyph_slot;
  logic [2:0]  in_glyph_row;
  logic [7:0]  in_row_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_pixel_address;
  logic [31:0] out_pixel_value;
  logic        out_write_valid;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  text_render_board render_board;
  logic [7:0]       rows_loaded [64];
  bit               quiet;
  int               stall_left;
  int               cycle_count;

  bitmap_text_renderer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_first_of_string (in_first_of_string),
    .in_char_code       (in_char_code),
    .in_glyph_slot      (in_glyph_slot),
    .in_glyph_row       (in_glyph_row),
    .in_row_bits        (in_row_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_address  (out_pixel_address),
    .out_pixel_value    (out_pixel_value),
    .out_write_valid    (out_write_valid),
    .out_status         (out_status),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver back-pressure: mostly short stalls, occasionally a long one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every result transfer goes to the scoreboard.
  always @(posedge clk) begin : result_monitor
    pixel_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.addr   = out_pixel_address;
      got.value  = out_pixel_value;
      got.wr     = out_write_valid;
      got.status = status_t'(out_status);
      got.last   = out_last;
      render_board.check_pixel(got);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_text_renderer_top regression: fail");
      $finish;
    end
  end

  // Drive one item and hold it until the transfer takes place.
  task automatic send_item(render_item_t it);
    int gap;
    gap = quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= it.op;
    in_first_of_string <= it.first;
    in_char_code       <= it.code;
    in_glyph_slot      <= it.slot;
    in_glyph_row       <= it.grow;
    in_row_bits        <= it.gbits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    render_board.note_item(it);
    if (it.op == OP_LOAD) rows_loaded[it.slot][it.grow] = 1'b1;
  endtask

  task automatic send_load(bit first, logic [5:0] slot, logic [2:0] grow, logic [7:0] gbits);
    render_item_t it;
    it.op    = OP_LOAD;
    it.first = first;
    it.code  = 8'($urandom_range(0, 255));
    it.slot  = slot;
    it.grow  = grow;
    it.gbits = gbits;
    send_item(it);
  endtask

  // A character item; any glyph rows it would read are loaded first.
  task automatic send_char(bit first, logic [7:0] code);
    render_item_t it;
    int           g;
    g = slot_for_code(code);
    if (g >= 0)
      for (int r = 0; r < 8; r++)
        if (!rows_loaded[g][r]) send_load(1'b0, 6'(g), 3'(r), 8'($urandom));
    it.op    = OP_CHAR;
    it.first = first;
    it.code  = code;
    it.slot  = 6'($urandom_range(0, 63));
    it.grow  = 3'($urandom_range(0, 7));
    it.gbits = 8'($urandom);
    send_item(it);
  endtask

  // Mostly strings of drawable characters with some line control, plus
  // stray loads and codes of any value.
  task automatic random_run(int count);
    int r;
    int c;
    for (int k = 0; k < count; k++) begin
      if (k % 24 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_load($urandom_range(0, 7) == 0, 6'($urandom_range(0, 63)),
                  3'($urandom_range(0, 7)), 8'($urandom));
      end else begin
        c = $urandom_range(0, 99);
        if (c < 55)
          send_char($urandom_range(0, 7) == 0, code_for_slot($urandom_range(0, 42)));
        else if (c < 75)
          send_char($urandom_range(0, 7) == 0, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        else
          send_char($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
      end
    end
    quiet = 1'b0;
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    render_board.write_reg(idx, d);
  endtask

  task automatic apply_setting(logic [31:0] ox, logic [31:0] oy, logic [31:0] pitch,
                               logic [31:0] ink_val, logic [31:0] w, logic [31:0] h,
                               logic [31:0] fb);
    write_cfg(REG_ORIGIN_X, ox);
    write_cfg(REG_ORIGIN_Y, oy);
    write_cfg(REG_LINE_PITCH, pitch);
    write_cfg(REG_INK_COLOR, ink_val);
    write_cfg(REG_SCREEN_WIDTH, w);
    write_cfg(REG_SCREEN_HEIGHT, h);
    write_cfg(REG_FRAME_BASE, fb);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every expected result has been taken and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (render_board.expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int ox;
    int oy;
    render_board = new();
    foreach (rows_loaded[i]) rows_loaded[i] = 8'h00;
    rst_n              = 1'b0;
    quiet              = 1'b0;
    cycle_count        = 0;
    in_valid           = 1'b0;
    in_opcode          = 1'b0;
    in_first_of_string = 1'b0;
    in_char_code       = 8'h00;
    in_glyph_slot      = 6'h00;
    in_glyph_row       = 3'h0;
    in_row_bits        = 8'h00;
    cfg_valid          = 1'b0;
    cfg_index          = 3'h0;
    cfg_wdata          = 32'h0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults: every character group, controls and unknown codes.
    send_load(1'b1, 6'd63, 3'd7, 8'hFF);
    send_load(1'b0, 6'd0, 3'd0, 8'h00);
    send_char(1'b1, CHAR_UPPER_A);
    send_char(1'b0, CHAR_UPPER_Z);
    send_char(1'b0, CHAR_DIGIT_9);
    send_char(1'b0, CHAR_QMARK);
    send_char(1'b0, CHAR_STAR);
    send_char(1'b0, CHAR_MINUS);
    send_char(1'b0, CHAR_SPACE);
    send_char(1'b0, CHAR_CR);
    send_char(1'b0, CHAR_LF);
    send_char(1'b0, 8'h00);
    send_char(1'b0, 8'hFF);
    send_char(1'b0, 8'h80);
    send_char(1'b0, 8'h7F);
    random_run(RANDOM_PER_PHASE);
    settle();

    // Largest values: addresses wrap, the second line is out of space, and a
    // load that starts a string clears the halt.
    apply_setting(32'hFFF, 32'hFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'd4096, 32'd4096,
                  32'hFFFF_FFFF);
    send_char(1'b1, CHAR_UPPER_A);
    send_char(1'b0, CHAR_DIGIT_0);
    send_char(1'b0, CHAR_LF);
    send_load(1'b1, 6'd1, 3'd0, 8'hA5);
    send_char(1'b0, code_for_slot(1));
    random_run(RANDOM_PER_PHASE);
    settle();

    // Smallest values: every character wraps and the next one runs out of space.
    apply_setting(32'h0, 32'h0, 32'h0, 32'h0, 32'd1, 32'd1, 32'h0);
    send_char(1'b1, CHAR_UPPER_Z);
    send_char(1'b0, CHAR_CR);
    send_char(1'b1, CHAR_SPACE);
    random_run(RANDOM_PER_PHASE);
    settle();

    // Full-size screen: a run of unknown codes along a line, then line feeds.
    apply_setting(32'h0, 32'h0, 32'($urandom_range(0, 65535)), $urandom, 32'd4096, 32'd4096,
                  $urandom);
    send_char(1'b1, CHAR_STAR);
    repeat (8) send_char(1'b0, unknown_code());
    send_char(1'b0, CHAR_MINUS);
    repeat (8) send_char(1'b0, CHAR_LF);
    send_char(1'b0, CHAR_QMARK);
    settle();

    // Random settings sized so that strings mostly fit on the screen.
    repeat (3) begin
      ox = $urandom_range(0, 255);
      oy = $urandom_range(0, 255);
      apply_setting(32'(ox), 32'(oy), 32'($urandom_range(0, 65535)), $urandom,
                    32'(ox + $urandom_range(1, 512)), 32'(oy + $urandom_range(1, 256)),
                    $urandom);
      random_run(RANDOM_PER_PHASE);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (render_board.errors == 0 && render_board.expected_pixels.size() == 0)
      $display("bitmap_text_renderer_top regression: pass");
    else
      $display("bitmap_text_renderer_top regression: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/btr_pkg.sv
rtl/core/btr_ram.sv
rtl/core/btr_cursor.sv
rtl/core/btr_draw.sv
rtl/core/bitmap_text_renderer_top.sv
rtl/core/btr_checker.sv
dv/bitmap_text_renderer_top_tb.sv
